[sv/ihb_pkg.sv]
// ----------------------------------------------------------------------------
// IPv4 header builder package
// Shared item types, register indexes and header constants.
// ----------------------------------------------------------------------------
package ihb_pkg;

   localparam int CsrDataWidth = 48;

   localparam logic [15:0] EthertypeIpv4 = 16'h0800;
   localparam logic [7:0]  VerIhlByte    = 8'h45;
   localparam logic [15:0] HdrBytes      = 16'd20;
   localparam logic [15:0] MaxPayload    = 16'd65515;
   localparam logic [7:0]  ProtoIcmp     = 8'd1;
   localparam logic [7:0]  TtlReset      = 8'd64;
   localparam logic [15:0] IdentReset    = 16'd0;

   typedef enum logic [1:0] {
      CSR_SOURCE_MAC  = 2'd0,
      CSR_SOURCE_IP   = 2'd1,
      CSR_TTL         = 2'd2,
      CSR_IDENT_START = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [31:0] dest_ip;
      logic [15:0] payload_length;
      logic [7:0]  proto_number;
      logic [15:0] icmp_ident;
   } req_type;

   typedef struct packed {
      logic [47:0] eth_source;
      logic [15:0] eth_type;
      logic [7:0]  ver_ihl;
      logic [7:0]  service_type;
      logic [15:0] total_length;
      logic [15:0] ident;
      logic [15:0] frag_field;
      logic [7:0]  hop_limit;
      logic [7:0]  proto_out;
      logic [15:0] header_checksum;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
   } rsp_type;

   typedef struct packed {
      logic [47:0] source_mac;
      logic [31:0] source_ip;
      logic [7:0]  time_to_live;
   } cfg_type;

endpackage

[sv/ihb_regs.sv]
// ----------------------------------------------------------------------------
// IPv4 header builder configuration registers
// Holds the interface settings and the identification counter.
// ----------------------------------------------------------------------------
module ihb_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  ihb_pkg::csr_index_type        csr_index,
   input  logic [ihb_pkg::CsrDataWidth-1:0] csr_wdata,
   input  logic                          ident_bump,
   output ihb_pkg::cfg_type              cfg,
   output logic [15:0]                   ident_count
);
   import ihb_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic [15:0] ident_ff, ident_in;

   always_comb begin
      cfg_in   = cfg_ff;
      ident_in = ident_ff;
      if (ident_bump) begin
         ident_in = ident_ff + 16'd1;
      end
      if (csr_we) begin
         unique case (csr_index)
            CSR_SOURCE_MAC:  cfg_in.source_mac   = csr_wdata[47:0];
            CSR_SOURCE_IP:   cfg_in.source_ip    = csr_wdata[31:0];
            CSR_TTL:         cfg_in.time_to_live = csr_wdata[7:0];
            CSR_IDENT_START: ident_in            = csr_wdata[15:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_mac   <= '0;
         cfg_ff.source_ip    <= '0;
         cfg_ff.time_to_live <= TtlReset;
         ident_ff            <= IdentReset;
      end else begin
         cfg_ff   <= cfg_in;
         ident_ff <= ident_in;
      end
   end

   assign cfg         = cfg_ff;
   assign ident_count = ident_ff;

endmodule

[sv/ihb_pipe.sv]
// ----------------------------------------------------------------------------
// IPv4 header builder datapath
// Input register, header and checksum logic, and result register.
// ----------------------------------------------------------------------------
module ihb_pipe (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ihb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ihb_pkg::rsp_type rsp_data,
   input  ihb_pkg::cfg_type cfg,
   input  logic [15:0]      ident_count,
   output logic             ident_bump
);
   import ihb_pkg::*;

   typedef struct packed {
      logic [31:0] dest_ip;
      logic [15:0] total_length;
      logic [7:0]  proto_number;
      logic [15:0] ident;
   } stage_type;

   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;

   logic        accept, s2_free, s1_move, is_icmp;
   logic [15:0] payload_sat;
   logic [19:0] csum_sum;
   logic [16:0] csum_fold1;
   logic [15:0] csum_fold2;

   assign s2_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && s2_free;
   assign req_stall  = s1_valid_ff && !s2_free;
   assign accept     = req_valid && !req_stall;
   assign is_icmp    = (req_data.proto_number == ProtoIcmp);
   assign ident_bump = accept && !is_icmp;

   always_comb begin
      payload_sat = (req_data.payload_length > MaxPayload) ? MaxPayload
                                                            : req_data.payload_length;
      s1_in.dest_ip      = req_data.dest_ip;
      s1_in.total_length = payload_sat + HdrBytes;
      s1_in.proto_number = req_data.proto_number;
      s1_in.ident        = is_icmp ? req_data.icmp_ident : ident_count;
   end

   always_comb begin
      csum_sum = 20'({VerIhlByte, 8'h00}) + 20'(s1_ff.total_length)
               + 20'(s1_ff.ident) + 20'({cfg.time_to_live, s1_ff.proto_number})
               + 20'(cfg.source_ip[31:16]) + 20'(cfg.source_ip[15:0])
               + 20'(s1_ff.dest_ip[31:16]) + 20'(s1_ff.dest_ip[15:0]);
      csum_fold1 = 17'(csum_sum[15:0]) + 17'(csum_sum[19:16]);
      csum_fold2 = csum_fold1[15:0] + 16'(csum_fold1[16]);

      rsp_in.eth_source      = cfg.source_mac;
      rsp_in.eth_type        = EthertypeIpv4;
      rsp_in.ver_ihl         = VerIhlByte;
      rsp_in.service_type    = 8'h00;
      rsp_in.total_length    = s1_ff.total_length;
      rsp_in.ident           = s1_ff.ident;
      rsp_in.frag_field      = 16'h0000;
      rsp_in.hop_limit       = cfg.time_to_live;
      rsp_in.proto_out       = s1_ff.proto_number;
      rsp_in.header_checksum = ~csum_fold2;
      rsp_in.src_addr        = cfg.source_ip;
      rsp_in.dst_addr        = s1_ff.dest_ip;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sv/ipv4_header_builder_top.sv]
// ----------------------------------------------------------------------------
// IPv4 header builder
// Builds the Ethernet source, ethertype and full IPv4 header with checksum
// for each transmit request.
//
//   Channel   Direction   Ports                           Carries
//   req       in          req_valid, req_stall, req_data  one transmit request
//   rsp       out         rsp_valid, rsp_stall, rsp_data  one header item
//   csr       in          csr_we, csr_index, csr_wdata    register write
//
// An item enters the input register when it is accepted and moves on to the
// result register once that register is free or being taken; one item is
// accepted every cycle while the result side keeps up. The identification
// value is taken from the counter at acceptance, or from icmp_ident for ICMP.
// Reset is synchronous and loads the register defaults (TTL 64, counter 0).
// A stall on rsp holds the result register; req stalls only once the input
// register is also full.
// ----------------------------------------------------------------------------
module ipv4_header_builder_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ihb_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ihb_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  ihb_pkg::csr_index_type            csr_index,
   input  logic [ihb_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import ihb_pkg::*;

   cfg_type     cfg;
   logic [15:0] ident_count;
   logic        ident_bump;

   ihb_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .ident_bump  (ident_bump),
      .cfg         (cfg),
      .ident_count (ident_count)
   );

   ihb_pipe u_pipe (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .cfg         (cfg),
      .ident_count (ident_count),
      .ident_bump  (ident_bump)
   );

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the result side is free");

   a_ident_advance: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.proto_number != ProtoIcmp) && !csr_we)
      |=> (ident_count == 16'($past(ident_count) + 16'd1)))
      else $error("identification counter did not advance");

   a_icmp_hold: assert property (@(posedge clock) disable iff (reset)
      (!csr_we && !(req_valid && !req_stall && (req_data.proto_number != ProtoIcmp)))
      |=> $stable(ident_count))
      else $error("identification counter changed without a non-ICMP item");

   a_total_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.total_length >= HdrBytes))
      else $error("total length below header size");

endmodule

[tb/ipv4_header_builder_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IPv4 header builder testbench
// A short table of directed requests and register writes is followed by
// several phases of random requests, each under a new register setting.
// Every accepted request is run through a local header predictor, and every
// header item that leaves the block is compared field by field with the
// oldest prediction. Both channels idle at random, and the result side
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module ipv4_header_builder_top_test;
   import ihb_pkg::*;

   localparam int CycleLimit   = 300000;
   localparam int LongHold     = 80;
   localparam int SettleCycles = 6;
   localparam int RandomItems  = 530;
   localparam int Phases       = 6;
   localparam int MaxPrinted   = 40;

   typedef enum logic {ROW_REQUEST, ROW_CSR_WRITE} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      csr_index_type           reg_index;
      logic [CsrDataWidth-1:0] wdata;
      req_type                 request;
      bit                      typed;
      logic [15:0]             total;
      logic [15:0]             ident;
      logic [15:0]             checksum;
   } plan_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_we = 1'b0;
   csr_index_type           csr_index = CSR_SOURCE_MAC;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   logic [47:0] cfg_mac;
   logic [31:0] cfg_ip;
   logic [7:0]  cfg_ttl;
   logic [15:0] ident_count;

   rsp_type      expected_headers[$];
   plan_row_type plan[$];

   int   mismatch_count = 0;
   int   headers_checked = 0;
   int   requests_sent = 0;
   int   icmp_sent = 0;
   int   oversized_sent = 0;
   int   csr_writes = 0;
   int   cycle_count = 0;
   int   req_gap_pct = 25;
   int   rsp_stall_pct = 25;
   logic rsp_hold_request = 1'b0;

   ipv4_header_builder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type build_header(input req_type r);
      rsp_type     h;
      logic [15:0] plen;
      logic [31:0] sum;
      plen = (r.payload_length > MaxPayload) ? MaxPayload : r.payload_length;
      h.eth_source   = cfg_mac;
      h.eth_type     = EthertypeIpv4;
      h.ver_ihl      = VerIhlByte;
      h.service_type = '0;
      h.total_length = HdrBytes + plen;
      if (r.proto_number == ProtoIcmp) begin
         h.ident = r.icmp_ident;
      end else begin
         h.ident = ident_count;
         ident_count = ident_count + 16'd1;
      end
      h.frag_field = '0;
      h.hop_limit  = cfg_ttl;
      h.proto_out  = r.proto_number;
      h.src_addr   = cfg_ip;
      h.dst_addr   = r.dest_ip;
      sum = 32'({VerIhlByte, 8'h00}) + 32'(h.total_length) + 32'(h.ident)
          + 32'({cfg_ttl, r.proto_number}) + 32'(cfg_ip[31:16]) + 32'(cfg_ip[15:0])
          + 32'(r.dest_ip[31:16]) + 32'(r.dest_ip[15:0]);
      while (sum[31:16] != 16'd0) sum = 32'(sum[15:0]) + 32'(sum[31:16]);
      h.header_checksum = ~sum[15:0];
      return h;
   endfunction

   function automatic void apply_register(input csr_index_type idx,
                                          input logic [CsrDataWidth-1:0] data);
      case (idx)
         CSR_SOURCE_MAC: begin
            cfg_mac = data[47:0];
         end
         CSR_SOURCE_IP: begin
            cfg_ip = data[31:0];
         end
         CSR_TTL: begin
            cfg_ttl = data[7:0];
         end
         CSR_IDENT_START: begin
            ident_count = data[15:0];
         end
         default: begin
         end
      endcase
   endfunction

   function automatic int idle_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.dest_ip    = $urandom;
      r.icmp_ident = 16'($urandom);
      case ($urandom_range(0, 9))
         0: begin
            r.payload_length = '0;
         end
         1: begin
            r.payload_length = MaxPayload;
         end
         2: begin
            r.payload_length = 16'($urandom_range(65516, 65535));
         end
         default: begin
            r.payload_length = 16'($urandom_range(0, 65515));
         end
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            r.proto_number = ProtoIcmp;
         end
         3: begin
            r.proto_number = 8'h00;
         end
         4: begin
            r.proto_number = 8'hFF;
         end
         default: begin
            r.proto_number = 8'($urandom);
         end
      endcase
      return r;
   endfunction

   function automatic logic [CsrDataWidth-1:0] random_register_value(input csr_index_type idx);
      logic [CsrDataWidth-1:0] v;
      case ($urandom_range(0, 3))
         0: begin
            v = '0;
         end
         1: begin
            v = '1;
         end
         default: begin
            v = CsrDataWidth'({$urandom, $urandom});
         end
      endcase
      if (idx == CSR_IDENT_START && $urandom_range(0, 1) == 1) begin
         v[15:0] = 16'($urandom_range(65500, 65535));
      end
      return v;
   endfunction

   function automatic plan_row_type request_row(input logic [31:0] dest,
                                                input logic [15:0] plen,
                                                input logic [7:0] proto,
                                                input logic [15:0] icmp_id,
                                                input bit typed,
                                                input logic [15:0] total,
                                                input logic [15:0] ident,
                                                input logic [15:0] checksum);
      plan_row_type row;
      row.kind      = ROW_REQUEST;
      row.reg_index = CSR_SOURCE_MAC;
      row.wdata     = '0;
      row.request   = '{dest_ip: dest, payload_length: plen, proto_number: proto,
                        icmp_ident: icmp_id};
      row.typed     = typed;
      row.total     = total;
      row.ident     = ident;
      row.checksum  = checksum;
      return row;
   endfunction

   function automatic plan_row_type register_row(input csr_index_type idx,
                                                 input logic [CsrDataWidth-1:0] data);
      plan_row_type row;
      row          = request_row('0, '0, '0, '0, 1'b0, '0, '0, '0);
      row.kind     = ROW_CSR_WRITE;
      row.reg_index = idx;
      row.wdata    = data;
      return row;
   endfunction

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      if (mismatch_count < MaxPrinted) begin
         $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [47:0] got,
                              input logic [47:0] want);
      if (got !== want) report_mismatch(name, got, want);
   endtask

   task automatic write_register(input csr_index_type idx,
                                 input logic [CsrDataWidth-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_register(idx, data);
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_headers.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic send_request(input req_type r, input bit typed, input logic [15:0] total,
                               input logic [15:0] ident, input logic [15:0] checksum);
      int      gap;
      rsp_type h;
      gap = 0;
      if ($urandom_range(0, 99) < req_gap_pct) gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      h = build_header(r);
      if (typed) begin
         h.total_length    = total;
         h.ident           = ident;
         h.header_checksum = checksum;
      end
      expected_headers.push_back(h);
      requests_sent++;
      if (r.proto_number == ProtoIcmp) icmp_sent++;
      if (r.payload_length > MaxPayload) oversized_sent++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timed out after %0d cycles with %0d headers outstanding.",
                  cycle_count, expected_headers.size());
         $display("ipv4_header_builder_top_test failed");
         $finish;
      end
   end

   always @(posedge clock) begin : header_checker
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_headers.size() == 0) begin
            report_mismatch("unexpected header item", 48'(rsp_data.ident), '0);
         end else begin
            want = expected_headers.pop_front();
            check_field("eth_source", rsp_data.eth_source, want.eth_source);
            check_field("eth_type", 48'(rsp_data.eth_type), 48'(want.eth_type));
            check_field("ver_ihl", 48'(rsp_data.ver_ihl), 48'(want.ver_ihl));
            check_field("service_type", 48'(rsp_data.service_type),
                        48'(want.service_type));
            check_field("total_length", 48'(rsp_data.total_length),
                        48'(want.total_length));
            check_field("ident", 48'(rsp_data.ident), 48'(want.ident));
            check_field("frag_field", 48'(rsp_data.frag_field), 48'(want.frag_field));
            check_field("hop_limit", 48'(rsp_data.hop_limit), 48'(want.hop_limit));
            check_field("proto_out", 48'(rsp_data.proto_out), 48'(want.proto_out));
            check_field("header_checksum", 48'(rsp_data.header_checksum),
                        48'(want.header_checksum));
            check_field("src_addr", 48'(rsp_data.src_addr), 48'(want.src_addr));
            check_field("dst_addr", 48'(rsp_data.dst_addr), 48'(want.dst_addr));
            headers_checked++;
         end
      end
   end

   initial begin : result_backpressure
      int run;
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request <= 1'b0;
            rsp_stall <= 1'b1;
            repeat (LongHold) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            run = idle_length();
            rsp_stall <= 1'b1;
            repeat (run) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      int            i;
      int            p;
      int            n;
      int            k;
      csr_index_type idx;

      cfg_mac     = '0;
      cfg_ip      = '0;
      cfg_ttl     = TtlReset;
      ident_count = IdentReset;

      // Reset values first, then the field extremes, saturation and ICMP.
      plan.push_back(request_row(32'h0, 16'd0, 8'h00, 16'h0000, 1'b1,
                                 16'h0014, 16'h0000, 16'h7AEB));
      plan.push_back(request_row(32'hFFFF_FFFF, 16'd65515, 8'hFF, 16'hFFFF, 1'b1,
                                 16'hFFFF, 16'h0001, 16'h79FF));
      plan.push_back(request_row(32'h0, 16'hFFFF, 8'h06, 16'h0000, 1'b1,
                                 16'hFFFF, 16'h0002, 16'h7AF7));
      plan.push_back(request_row(32'h0, 16'hFFEC, 8'h11, 16'h1234, 1'b1,
                                 16'hFFFF, 16'h0003, 16'h7AEB));
      plan.push_back(request_row(32'h0, 16'd0, ProtoIcmp, 16'hFFFF, 1'b1,
                                 16'h0014, 16'hFFFF, 16'h7AEA));
      plan.push_back(request_row(32'h0, 16'd100, ProtoIcmp, 16'h0000, 1'b1,
                                 16'h0078, 16'h0000, 16'h7A86));
      plan.push_back(request_row(32'h0, 16'd65515, 8'hFE, 16'hFFFF, 1'b1,
                                 16'hFFFF, 16'h0004, 16'h79FD));
      plan.push_back(request_row(32'h0A00_0001, 16'd1, 8'h02, 16'h5555, 1'b0,
                                 '0, '0, '0));
      plan.push_back(register_row(CSR_SOURCE_MAC, 48'hFFFF_FFFF_FFFF));
      plan.push_back(register_row(CSR_SOURCE_IP, 48'hFFFF_FFFF_FFFF));
      plan.push_back(register_row(CSR_TTL, 48'hFFFF_FFFF_FFFF));
      plan.push_back(register_row(CSR_IDENT_START, 48'h1234_5678_FFFE));
      // The counter wraps from all ones to zero.
      plan.push_back(request_row(32'h0, 16'd0, 8'h06, 16'h0000, 1'b1,
                                 16'h0014, 16'hFFFE, 16'hBBE5));
      plan.push_back(request_row(32'h0, 16'd0, 8'h06, 16'h0000, 1'b1,
                                 16'h0014, 16'hFFFF, 16'hBBE4));
      plan.push_back(request_row(32'h0, 16'd0, 8'h06, 16'h0000, 1'b1,
                                 16'h0014, 16'h0000, 16'hBBE4));
      plan.push_back(request_row(32'hC0A8_0101, 16'd1500, ProtoIcmp, 16'hAAAA, 1'b0,
                                 '0, '0, '0));
      plan.push_back(register_row(CSR_TTL, 48'h0));
      plan.push_back(register_row(CSR_SOURCE_MAC, 48'h0123_4567_89AB));
      plan.push_back(register_row(CSR_SOURCE_IP, 48'h0000_C0A8_0064));
      plan.push_back(request_row(32'h0808_0808, 16'h8000, 8'h80, 16'h0000, 1'b0,
                                 '0, '0, '0));
      plan.push_back(request_row(32'h7F00_0001, 16'd65514, 8'h11, 16'h0001, 1'b0,
                                 '0, '0, '0));
      plan.push_back(request_row(32'h8000_0000, 16'd40, 8'h06, 16'h8000, 1'b0,
                                 '0, '0, '0));
      plan.push_back(register_row(CSR_IDENT_START, 48'h0));
      plan.push_back(request_row(32'hFFFF_0000, 16'd0, 8'hFF, 16'h7FFF, 1'b0,
                                 '0, '0, '0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < plan.size(); i++) begin
         if (plan[i].kind == ROW_CSR_WRITE) begin
            drain_results();
            write_register(plan[i].reg_index, plan[i].wdata);
         end else begin
            send_request(plan[i].request, plan[i].typed, plan[i].total,
                         plan[i].ident, plan[i].checksum);
         end
      end

      for (p = 0; p < Phases; p++) begin
         drain_results();
         for (k = 0; k < 4; k++) begin
            idx = csr_index_type'(k);
            write_register(idx, random_register_value(idx));
         end
         if (p == 2) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct   = $urandom_range(5, 50);
            rsp_stall_pct = $urandom_range(5, 50);
         end
         for (n = 0; n < RandomItems / Phases; n++) begin
            if (p == 3 && n == 10) rsp_hold_request <= 1'b1;
            if (p == 1 && n == 45) drain_results();
            send_request(random_request(), 1'b0, '0, '0, '0);
         end
      end

      req_valid <= 1'b0;
      while (expected_headers.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("Sent %0d requests (%0d ICMP, %0d with oversized payload) and checked %0d headers.",
               requests_sent, icmp_sent, oversized_sent, headers_checked);
      $display("Made %0d register writes over %0d random phases; %0d mismatches.",
               csr_writes, Phases, mismatch_count);
      if (mismatch_count == 0) begin
         $display("ipv4_header_builder_top_test passed");
      end else begin
         $display("ipv4_header_builder_top_test failed");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/ihb_pkg.sv
sv/ihb_regs.sv
sv/ihb_pipe.sv
sv/ipv4_header_builder_top.sv
tb/ipv4_header_builder_top_test.sv
